/* hw/rtl/sdem_pkg.sv */
// ----------------------------------------------------------------------------
// sdem_pkg
// Shared types and constants for the sorted duplicate entry merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdem_pkg;

  // sizing
  localparam int MAX_MODES  = 4;
  localparam int COORD_BITS = 32;
  localparam int IN_COORDS  = 4;
  localparam int USED_LIMIT = (MAX_MODES < IN_COORDS) ? MAX_MODES : IN_COORDS;

  localparam int COORD_W  = 32;
  localparam int VALUE_W  = 32;
  localparam int SUM_W    = 48;
  localparam int COUNT_W  = 32;
  localparam int MODE_W   = 3;

  localparam logic [COORD_W-1:0] COORD_MASK =
    (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} :
                              COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0]      COUNT_MAX = {COUNT_W{1'b1}};

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_LSB = 2;
  localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;

  localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT = CFG_IDX_W'(0);
  localparam logic [MODE_W-1:0]    MODE_COUNT_RESET = MODE_W'(3);

  // input op codes
  typedef enum logic {
    OP_ENTRY = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [COORD_W-1:0]        coord_a;
    logic [COORD_W-1:0]        coord_b;
    logic [COORD_W-1:0]        coord_c;
    logic [COORD_W-1:0]        coord_d;
    logic signed [VALUE_W-1:0] entry_value;
  } in_beat_t;

  typedef struct packed {
    logic                      entry_valid;
    logic [COORD_W-1:0]        out_coord_a;
    logic [COORD_W-1:0]        out_coord_b;
    logic [COORD_W-1:0]        out_coord_c;
    logic [COORD_W-1:0]        out_coord_d;
    logic signed [SUM_W-1:0]   sum_value;
    logic                      is_last;
    logic [COUNT_W-1:0]        removed_count;
  } out_beat_t;

  // merge core to output stage
  typedef struct packed {
    logic      emit;
    out_beat_t beat;
  } merge_res_t;

  // effective number of compared modes, zero treated as one, clamped above
  function automatic logic [MODE_W-1:0] used_modes(input logic [MODE_W-1:0] mc);
    logic [MODE_W-1:0] n;
    n = mc;
    if (n == MODE_W'(0)) begin
      n = MODE_W'(1);
    end
    if (n > MODE_W'(USED_LIMIT)) begin
      n = MODE_W'(USED_LIMIT);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sdem_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sdem_cfg_regs
// APB-style register file holding the mode count.
// ----------------------------------------------------------------------------
`default_nettype none

module sdem_cfg_regs
  import sdem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [MODE_W-1:0]     mode_count
);

  logic [MODE_W-1:0]    mode_count_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_count_r <= MODE_COUNT_RESET;
    end else if (wr_en && (reg_idx == REG_MODE_COUNT)) begin
      mode_count_r <= pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODE_COUNT) begin
      prdata = CFG_DATA_W'(mode_count_r);
    end
  end

  assign mode_count = mode_count_r;

endmodule

`default_nettype wire

/* hw/rtl/sdem_merge.sv */
// ----------------------------------------------------------------------------
// sdem_merge
// Pending entry state, coordinate compare and saturating accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module sdem_merge
  import sdem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire in_beat_t          in_beat,
  input  wire logic [MODE_W-1:0] mode_count,
  output merge_res_t             res
);

  logic                      pending_present_r, pending_present_nxt;
  logic [COORD_W-1:0]        pending_coords_r [IN_COORDS];
  logic [COORD_W-1:0]        pending_coords_nxt [IN_COORDS];
  logic signed [SUM_W-1:0]   pending_sum_r, pending_sum_nxt;
  logic [COUNT_W-1:0]        merged_counter_r, merged_counter_nxt;

  logic [COORD_W-1:0]        in_coords [IN_COORDS];
  logic [MODE_W-1:0]         n_used;
  logic                      same;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;

  assign in_coords[0] = in_beat.coord_a & COORD_MASK;
  assign in_coords[1] = in_beat.coord_b & COORD_MASK;
  assign in_coords[2] = in_beat.coord_c & COORD_MASK;
  assign in_coords[3] = in_beat.coord_d & COORD_MASK;

  assign n_used = used_modes(mode_count);

  always_comb begin
    same = 1'b1;
    for (int m = 0; m < IN_COORDS; m++) begin
      if ((MODE_W'(m) < n_used) && (in_coords[m] != pending_coords_r[m])) begin
        same = 1'b0;
      end
    end
  end

  assign sum_wide = $signed({pending_sum_r[SUM_W-1], pending_sum_r})
                  + (SUM_W+1)'(in_beat.entry_value);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    pending_present_nxt = pending_present_r;
    pending_coords_nxt  = pending_coords_r;
    pending_sum_nxt     = pending_sum_r;
    merged_counter_nxt  = merged_counter_r;

    res.emit               = 1'b0;
    res.beat.entry_valid   = pending_present_r;
    res.beat.out_coord_a   = pending_present_r ? pending_coords_r[0] : '0;
    res.beat.out_coord_b   = pending_present_r ? pending_coords_r[1] : '0;
    res.beat.out_coord_c   = pending_present_r ? pending_coords_r[2] : '0;
    res.beat.out_coord_d   = pending_present_r ? pending_coords_r[3] : '0;
    res.beat.sum_value     = pending_present_r ? pending_sum_r : '0;
    res.beat.is_last       = 1'b0;
    res.beat.removed_count = '0;

    if (in_beat.op == OP_FLUSH) begin
      res.emit               = 1'b1;
      res.beat.is_last       = 1'b1;
      res.beat.removed_count = merged_counter_r;
      pending_present_nxt    = 1'b0;
      for (int m = 0; m < IN_COORDS; m++) begin
        pending_coords_nxt[m] = '0;
      end
      pending_sum_nxt    = '0;
      merged_counter_nxt = '0;
    end else if (pending_present_r && same) begin
      pending_sum_nxt = sum_sat;
      if (merged_counter_r != COUNT_MAX) begin
        merged_counter_nxt = merged_counter_r + COUNT_W'(1);
      end
    end else begin
      // new key: emit whatever is pending, then capture
      res.emit            = pending_present_r;
      pending_present_nxt = 1'b1;
      for (int m = 0; m < IN_COORDS; m++) begin
        pending_coords_nxt[m] = (MODE_W'(m) < n_used) ? in_coords[m] : '0;
      end
      pending_sum_nxt = SUM_W'(in_beat.entry_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_present_r <= 1'b0;
      for (int m = 0; m < IN_COORDS; m++) begin
        pending_coords_r[m] <= '0;
      end
      pending_sum_r    <= '0;
      merged_counter_r <= '0;
    end else if (in_fire) begin
      pending_present_r <= pending_present_nxt;
      pending_coords_r  <= pending_coords_nxt;
      pending_sum_r     <= pending_sum_nxt;
      merged_counter_r  <= merged_counter_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sdem_out_stage.sv */
// ----------------------------------------------------------------------------
// sdem_out_stage
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sdem_out_stage
  import sdem_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire merge_res_t res,
  output logic            slot_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_beat_t       out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;
  logic      load;

  assign slot_free = ~out_valid_r | out_ready;
  assign load      = in_fire & res.emit;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/sorted_duplicate_entry_merge.sv */
// ----------------------------------------------------------------------------
// sorted_duplicate_entry_merge
// Merges runs of equal-key sparse nonzeros from a sorted stream into one
// entry with a saturating 48-bit sum.
// ----------------------------------------------------------------------------
// output: each result beat is registered, appearing in the cycle after the input beat that causes it
// throughput: one input beat per cycle, set by the single compare/add path
//   between the pending-entry registers and the result register
// the input stalls only while a result beat waits and the consumer holds ready low
// reset: synchronous, active low; clears the pending entry, sum and merge
//   counter, empties the result register and sets mode_count to 3
`default_nettype none

module sorted_duplicate_entry_merge
  import sdem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // input beats
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_beat_t              in_data,

  // result beats
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_beat_t                  out_data,

  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic              in_fire;
  logic              slot_free;
  logic [MODE_W-1:0] mode_count;
  merge_res_t        res;

  // a beat is taken whenever the result register is empty or draining this cycle
  assign in_ready = slot_free;
  assign in_fire  = in_valid & in_ready;

  // mode_count register behind the apb port
  sdem_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .mode_count (mode_count)
  );

  // pending entry, key compare and accumulate; state advances on each taken beat
  sdem_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_beat    (in_data),
    .mode_count (mode_count),
    .res        (res)
  );

  // registered result toward the consumer, loaded only when a beat emits
  sdem_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
